// ----- src/itoa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants of the integer-to-ASCII field formatter.
// ----------------------------------------------------------------------------
package itoa_pkg;

   localparam int MaxFieldWidth = 48;
   localparam int MaxPrecision  = 40;
   localparam int MaxResults    = 48;
   localparam int DigitSlots    = 24;

   localparam logic [2:0] MODE_SDEC = 3'd0;
   localparam logic [2:0] MODE_UDEC = 3'd1;
   localparam logic [2:0] MODE_OCT  = 3'd2;
   localparam logic [2:0] MODE_HEX  = 3'd3;
   localparam logic [2:0] MODE_PTR  = 3'd4;
   localparam logic [2:0] MODE_CHAR = 3'd5;

   localparam logic [7:0] ASCII_ZERO  = 8'h30;
   localparam logic [7:0] ASCII_SPACE = 8'h20;
   localparam logic [7:0] ASCII_MINUS = 8'h2d;

   // character segments in output order
   typedef enum logic [2:0] {
      SEG_LPAD  = 3'd0,
      SEG_SIGN  = 3'd1,
      SEG_ZPAD  = 3'd2,
      SEG_ZEROS = 3'd3,
      SEG_DIGIT = 3'd4,
      SEG_RPAD  = 3'd5
   } seg_type;

   // controller -> datapath
   typedef struct packed {
      logic    load;      // capture a new transaction
      logic    conv_step; // one digit step
      logic    emit;      // load output register
      seg_type seg;
      logic    last;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       conv_done;
      logic       valid_mode;
      logic       char_mode;
      logic [5:0] lpad;
      logic       has_sign;
      logic [5:0] zpad;
      logic [5:0] zeros;
      logic [4:0] ndig;
      logic [5:0] rpad;
   } status_type;

   function automatic logic [7:0] hex_char(input logic [3:0] d);
      return (d < 4'd10) ? (ASCII_ZERO + {4'd0, d}) : (8'h57 + {4'd0, d});
   endfunction

endpackage

// ----- src/integer_to_ascii_field_formatter_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_field_formatter_unit
// One printf-style integer or character conversion per transaction, emitted
// as a stream of ASCII characters.
// ----------------------------------------------------------------------------
// Usage:
//  - req_ channel: one conversion per transaction. tdata carries mode,
//    value, field width, precision; tuser carries the three flags.
//  - rsp_ channel: one character per transaction, rsp_tlast on the final one.
//    A conversion that yields no characters (invalid mode, or zero at
//    precision zero with no width or sign) produces no transaction.
//  - Sequence: capture, then one digit per cycle (up to 16 digits for
//    64-bit pointer hex, 11 for octal, 10 for decimal, none for char),
//    then each segment in turn (up to 6) with its characters emitted
//    one at a time (up to 48 in all).
//  - Throughput: one conversion at a time; the serial digit extractor
//    and the one-character output register set this.
//  - Reset clears the sequencer and drops any pending character.
//  - A stalled rsp_tready holds the output register; the sequencer waits.
// ----------------------------------------------------------------------------
module integer_to_ascii_field_formatter_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // mode[2:0], value[66:3], field_width[73:67], min_digits[80:74], zero pad
   input  logic [87:0] req_tdata,
   // flag_left[0], flag_zero[1], flag_space[2]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_char[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);

   itoa_pkg::cmd_type    cmd;
   itoa_pkg::status_type status;
   logic [5:0]           seg_idx;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .status    (status),
      .cmd       (cmd),
      .seg_idx   (seg_idx)
   );

   itoa_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .mode        (req_tdata[2:0]),
      .value       (req_tdata[66:3]),
      .field_width (req_tdata[73:67]),
      .min_digits  (req_tdata[80:74]),
      .flag_left   (req_tuser[0]),
      .flag_zero   (req_tuser[1]),
      .flag_space  (req_tuser[2]),
      .cmd         (cmd),
      .seg_idx     (seg_idx),
      .status      (status),
      .out_char    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

   logic [6:0] unused_pad;
   assign unused_pad = req_tdata[87:81];

endmodule

// ----- src/itoa_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_datapath
// Operand capture, digit conversion (one digit per cycle), field sizing and
// character output register.
// ----------------------------------------------------------------------------
module itoa_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [2:0]           mode,
   input  logic [63:0]          value,
   input  logic signed [6:0]    field_width,
   input  logic signed [6:0]    min_digits,
   input  logic                 flag_left,
   input  logic                 flag_zero,
   input  logic                 flag_space,
   input  itoa_pkg::cmd_type    cmd,
   input  logic [5:0]           seg_idx,
   output itoa_pkg::status_type status,
   output logic [7:0]           out_char,
   output logic                 out_last
);

   logic [2:0]  mode_ff;
   logic [63:0] mag_ff, mag_in;
   logic [7:0]  char_ff;
   logic        left_ff, zero_ff, sign_ff, minus_ff, skip_ff;
   logic [5:0]  w_ff, prec_ff;
   logic [3:0]  dig_ff [itoa_pkg::DigitSlots];
   logic [4:0]  ndig_ff;
   logic        done_ff;
   logic [7:0]  och_ff;
   logic        olast_ff;

   // input decode
   logic [6:0]  wabs;
   logic [5:0]  wsat, psat;
   logic        lft, pabs, neg, m4;
   logic [31:0] lo;
   logic [63:0] mag0;

   always_comb begin
      wabs = field_width[6] ? 7'(-field_width) : field_width;
      wsat = (wabs > 7'(itoa_pkg::MaxFieldWidth)) ? 6'(itoa_pkg::MaxFieldWidth) : wabs[5:0];
      m4   = (mode == itoa_pkg::MODE_PTR);
      pabs = min_digits[6] || m4;
      psat = (min_digits > $signed(7'(itoa_pkg::MaxPrecision))) ? 6'(itoa_pkg::MaxPrecision)
                                                               : min_digits[5:0];
      lft  = flag_left || field_width[6];
      lo   = value[31:0];
      neg  = (mode == itoa_pkg::MODE_SDEC) && lo[31];
      mag0 = m4 ? value : (neg ? {32'd0, 32'(-lo)} : {32'd0, lo});
   end

   // one digit step
   logic [3:0]  d;
   logic [63:0] q;
   logic [32:0] q10;
   always_comb begin
      q10 = 33'((mag_ff[31:0] * 64'hCCCCCCCD) >> 35);
      unique case (mode_ff)
         itoa_pkg::MODE_OCT: begin d = {1'b0, mag_ff[2:0]}; q = mag_ff >> 3; end
         itoa_pkg::MODE_HEX,
         itoa_pkg::MODE_PTR: begin d = mag_ff[3:0]; q = mag_ff >> 4; end
         default: begin
            q = {31'd0, q10};
            d = 4'(mag_ff[31:0] - 32'(q10[31:0] * 32'd10));
         end
      endcase
      mag_in = q;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff     <= mode;
         mag_ff      <= mag0;
         char_ff     <= value[7:0];
         left_ff     <= lft;
         // zero padding only applies when no precision is given
         zero_ff     <= flag_zero && pabs && !lft;
         w_ff        <= wsat;
         prec_ff     <= pabs ? 6'd1 : psat;
         minus_ff    <= neg;
         sign_ff     <= neg || flag_space;
         skip_ff     <= !pabs && (psat == 6'd0) && (mag0 == 64'd0);
      end else if (cmd.conv_step) begin
         dig_ff[ndig_ff] <= d;
         mag_ff <= mag_in;
      end
      if (cmd.emit) begin
         olast_ff <= cmd.last;
         unique case (cmd.seg)
            itoa_pkg::SEG_SIGN:  och_ff <= minus_ff ? itoa_pkg::ASCII_MINUS
                                                    : itoa_pkg::ASCII_SPACE;
            itoa_pkg::SEG_ZPAD,
            itoa_pkg::SEG_ZEROS: och_ff <= itoa_pkg::ASCII_ZERO;
            itoa_pkg::SEG_DIGIT: och_ff <= (mode_ff == itoa_pkg::MODE_CHAR) ? char_ff
                                 : itoa_pkg::hex_char(dig_ff[seg_idx[4:0]]);
            default:             och_ff <= itoa_pkg::ASCII_SPACE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ndig_ff <= '0;
         done_ff <= 1'b0;
      end else if (cmd.load) begin
         ndig_ff <= '0;
         done_ff <= 1'b0;
      end else if (cmd.conv_step) begin
         ndig_ff <= ndig_ff + 5'd1;
         done_ff <= (mag_in == 64'd0) || (ndig_ff == 5'(itoa_pkg::DigitSlots - 1));
      end
   end

   // field sizing once digits are known
   logic [4:0] len;
   logic [5:0] zc;
   logic [6:0] body, padn, cpad;
   logic       chm;
   always_comb begin
      chm  = (mode_ff == itoa_pkg::MODE_CHAR);
      len  = skip_ff ? 5'd0 : ndig_ff;
      zc   = (prec_ff > {1'b0, len}) ? prec_ff - {1'b0, len} : 6'd0;
      body = 7'(len) + 7'(zc) + 7'(sign_ff);
      padn = ({1'b0, w_ff} > body) ? {1'b0, w_ff} - body : 7'd0;
      cpad = (w_ff > 6'd0) ? 7'(w_ff - 6'd1) : 7'd0;
      status.conv_done  = done_ff || skip_ff || chm;
      status.valid_mode = (mode <= itoa_pkg::MODE_CHAR);
      status.char_mode  = chm;
      status.has_sign   = sign_ff && !chm;
      status.zeros      = chm ? 6'd0 : zc;
      status.ndig       = chm ? 5'd1 : len;
      status.lpad       = chm ? (left_ff ? 6'd0 : cpad[5:0])
                              : ((!left_ff && !zero_ff) ? padn[5:0] : 6'd0);
      status.zpad       = (!chm && zero_ff) ? padn[5:0] : 6'd0;
      status.rpad       = left_ff ? (chm ? cpad[5:0] : padn[5:0]) : 6'd0;
   end

   assign out_char = och_ff;
   assign out_last = olast_ff;

endmodule

// ----- src/itoa_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: accept, digit conversion, then segment-by-segment emission with
// the output register as a one-entry buffer.
// ----------------------------------------------------------------------------
module itoa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  logic                 out_ready,
   output logic                 out_valid,
   input  itoa_pkg::status_type status,
   output itoa_pkg::cmd_type    cmd,
   output logic [5:0]           seg_idx
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_CONV = 2'd1,
      ST_EMIT = 2'd2
   } state_type;

   state_type         state_ff;
   itoa_pkg::seg_type seg_ff;
   logic [5:0]        cnt_ff;   // chars left in segment
   logic [5:0]        total_ff; // chars emitted
   logic              ovalid_ff;

   // remaining chars after the current segment
   logic [7:0] rest;
   always_comb begin
      rest = '0;
      if (seg_ff < itoa_pkg::SEG_SIGN)  rest = rest + 8'(status.has_sign);
      if (seg_ff < itoa_pkg::SEG_ZPAD)  rest = rest + 8'(status.zpad);
      if (seg_ff < itoa_pkg::SEG_ZEROS) rest = rest + 8'(status.zeros);
      if (seg_ff < itoa_pkg::SEG_DIGIT) rest = rest + 8'(status.ndig);
      if (seg_ff < itoa_pkg::SEG_RPAD)  rest = rest + 8'(status.rpad);
   end

   logic can_emit, active, last, in_seg;
   always_comb begin
      can_emit = !ovalid_ff || out_ready;
      in_seg   = (cnt_ff != 6'd0);
      active   = (state_ff == ST_EMIT) && in_seg && can_emit;
      last     = (cnt_ff == 6'd1 && rest == 8'd0)
                 || (total_ff == 6'(itoa_pkg::MaxResults - 1));
      in_ready = (state_ff == ST_IDLE) && !ovalid_ff;
      cmd.load      = in_ready && in_valid && status.valid_mode;
      cmd.conv_step = (state_ff == ST_CONV) && !status.conv_done;
      cmd.emit      = active;
      cmd.seg       = seg_ff;
      cmd.last      = last;
      // digits stored LSB first, emitted from the top
      seg_idx   = cnt_ff - 6'd1;
      out_valid = ovalid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         seg_ff    <= itoa_pkg::SEG_LPAD;
         cnt_ff    <= '0;
         total_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         if (ovalid_ff && out_ready) ovalid_ff <= 1'b0;
         if (active) ovalid_ff <= 1'b1;
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd.load) state_ff <= ST_CONV;
            end
            ST_CONV: begin
               if (status.conv_done) begin
                  state_ff <= ST_EMIT;
                  seg_ff   <= itoa_pkg::SEG_LPAD;
                  cnt_ff   <= status.lpad;
                  total_ff <= '0;
               end
            end
            default: begin
               if (active) begin
                  total_ff <= total_ff + 6'd1;
                  cnt_ff   <= cnt_ff - 6'd1;
                  if (last) state_ff <= ST_IDLE;
               end else if (!in_seg) begin
                  if (seg_ff == itoa_pkg::SEG_RPAD) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     seg_ff <= itoa_pkg::seg_type'(seg_ff + 3'd1);
                     unique case (itoa_pkg::seg_type'(seg_ff + 3'd1))
                        itoa_pkg::SEG_SIGN:  cnt_ff <= 6'(status.has_sign);
                        itoa_pkg::SEG_ZPAD:  cnt_ff <= status.zpad;
                        itoa_pkg::SEG_ZEROS: cnt_ff <= status.zeros;
                        itoa_pkg::SEG_DIGIT: cnt_ff <= 6'(status.ndig);
                        default:             cnt_ff <= status.rpad;
                     endcase
                  end
               end
            end
         endcase
      end
   end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer-to-ASCII field formatter. Conversions
// are streamed in with random gaps, the expected character stream of each is
// formatted locally, and every character on the result channel is compared
// in order with it.
// ----------------------------------------------------------------------------
module testbench;

   typedef struct {
      logic [2:0]  mode;
      logic [63:0] value;
      logic [6:0]  fwidth;
      logic [6:0]  prec;
      logic [2:0]  flags; // left, zero, space
   } conv_type;

   typedef struct {
      logic [7:0] ch;
      logic       last;
   } char_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [87:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   conv_type pending_convs[$];
   char_type expected_chars[$];
   bit    failed = 1'b0;
   bit    no_idle = 1'b0;
   int    idle_cnt = 0;
   int    stall_cnt = 0;
   int    quiet_cycles = 0;

   integer_to_ascii_field_formatter_unit DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Append one character to the expected stream, capped at MaxResults.
   task automatic push_char(input logic [7:0] c, inout int cnt);
      char_type e;
      if (cnt < itoa_pkg::MaxResults) begin
         e.ch = c;
         e.last = 1'b0;
         expected_chars.push_back(e);
         cnt++;
      end
   endtask

   task automatic format_conversion(input conv_type c);
      int w, p, len, zeros, body, padn, cnt;
      bit left, zpad, has_sign;
      logic [7:0] sign_ch;
      logic [63:0] mag;
      logic [7:0] dig[24];
      cnt = 0;
      len = 0;
      if (c.mode > itoa_pkg::MODE_CHAR) return;
      w = $signed(c.fwidth);
      p = $signed(c.prec);
      left = c.flags[0];
      zpad = c.flags[1];
      if (w < 0) begin
         left = 1'b1;
         w = -w;
      end
      if (w > itoa_pkg::MaxFieldWidth) w = itoa_pkg::MaxFieldWidth;
      if (p > itoa_pkg::MaxPrecision) p = itoa_pkg::MaxPrecision;
      if (p < 0) p = -1;
      if (c.mode == itoa_pkg::MODE_CHAR) begin
         if (!left) for (int i = 0; i < w - 1; i++) push_char(itoa_pkg::ASCII_SPACE, cnt);
         push_char(c.value[7:0], cnt);
         if (left) for (int i = 0; i < w - 1; i++) push_char(itoa_pkg::ASCII_SPACE, cnt);
      end else begin
         if (c.mode == itoa_pkg::MODE_PTR) begin
            p = -1;
            mag = c.value;
         end else begin
            mag = {32'd0, c.value[31:0]};
         end
         has_sign = 1'b0;
         sign_ch = itoa_pkg::ASCII_SPACE;
         if (c.mode == itoa_pkg::MODE_SDEC && mag[31]) begin
            has_sign = 1'b1;
            sign_ch = itoa_pkg::ASCII_MINUS;
            mag = (64'h1_0000_0000 - mag) & 64'h1_ffff_ffff;
         end else if (c.flags[2]) begin
            has_sign = 1'b1;
         end
         if (p >= 0) zpad = 1'b0;
         // digits gathered least significant first
         if (!(p == 0 && mag == 0)) begin
            do begin
               if (c.mode <= itoa_pkg::MODE_UDEC) begin
                  dig[len] = itoa_pkg::ASCII_ZERO + 8'(mag % 10);
                  mag = mag / 10;
               end else if (c.mode == itoa_pkg::MODE_OCT) begin
                  dig[len] = itoa_pkg::ASCII_ZERO + {5'd0, mag[2:0]};
                  mag = mag >> 3;
               end else begin
                  dig[len] = (mag[3:0] < 10) ? itoa_pkg::ASCII_ZERO + {4'd0, mag[3:0]}
                                             : 8'h57 + {4'd0, mag[3:0]};
                  mag = mag >> 4;
               end
               len++;
            end while (mag != 0 && len < 24);
         end
         if (p < 0) p = 1;
         zeros = (p > len) ? p - len : 0;
         body = len + zeros + (has_sign ? 1 : 0);
         padn = (w > body) ? w - body : 0;
         if (!left && !zpad)
            for (int i = 0; i < padn; i++) push_char(itoa_pkg::ASCII_SPACE, cnt);
         if (has_sign) push_char(sign_ch, cnt);
         if (!left && zpad)
            for (int i = 0; i < padn; i++) push_char(itoa_pkg::ASCII_ZERO, cnt);
         for (int i = 0; i < zeros; i++) push_char(itoa_pkg::ASCII_ZERO, cnt);
         for (int i = len - 1; i >= 0; i--) push_char(dig[i], cnt);
         if (left) for (int i = 0; i < padn; i++) push_char(itoa_pkg::ASCII_SPACE, cnt);
      end
      if (cnt > 0) expected_chars[$].last = 1'b1;
   endtask

   function automatic conv_type make_conv(input logic [2:0] m, input logic [63:0] v,
                                          input int w, input int p, input logic [2:0] f);
      conv_type c;
      c.mode = m;
      c.value = v;
      c.fwidth = 7'(w);
      c.prec = 7'(p);
      c.flags = f;
      return c;
   endfunction

   function automatic logic [63:0] rand_value();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 5))
         0: v = 64'(v[3:0]);
         1: v = {32'd0, 32'h8000_0000};
         2: v = 64'(v[15:0]);
         default: ;
      endcase
      return v;
   endfunction

   // Driver: one conversion per transaction, random gap bursts.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) format_conversion(pending_convs.pop_front());
         if (idle_cnt > 0) begin
            idle_cnt <= idle_cnt - 1;
            req_tvalid <= 1'b0;
         end else if ((!req_tvalid || req_tready) && !no_idle && $urandom_range(0, 3) == 0) begin
            idle_cnt <= $urandom_range(0, 7);
            req_tvalid <= 1'b0;
         end else if (req_tvalid && !req_tready) begin
            // hold the current transaction
         end else if (pending_convs.size() > 0) begin
            conv_type n;
            n = pending_convs[0];
            req_tvalid <= 1'b1;
            req_tdata <= {7'd0, n.prec, n.fwidth, n.value, n.mode};
            req_tuser <= n.flags;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Monitor: check each character against the expected stream.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_chars.size() == 0) begin
               $error("unexpected character %h", rsp_tdata);
               failed = 1'b1;
            end else begin
               char_type e;
               e = expected_chars.pop_front();
               if (rsp_tdata !== e.ch) begin
                  $error("out_char expected %h actual %h", e.ch, rsp_tdata);
                  failed = 1'b1;
               end
               if (rsp_tlast !== e.last) begin
                  $error("last_char expected %b actual %b", e.last, rsp_tlast);
                  failed = 1'b1;
               end
            end
         end
         if (stall_cnt > 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_tready <= 1'b0;
         end else if (!no_idle && $urandom_range(0, 4) == 0) begin
            stall_cnt <= $urandom_range(0, 7);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Watchdog: cycles without any accepted transaction.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 2000) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      int k;
      // directed: extremes, every mode, special cases
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'h8000_0000, 0, -1, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'h7fff_ffff, 15, -1, 3'b110));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'hffff_ffff, -12, 5, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_UDEC, 64'hffff_ffff, 0, -1, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_UDEC, 64'd0, 0, 0, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_UDEC, 64'd0, 6, 0, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'd0, 0, 0, 3'b100));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_OCT, 64'hffff_ffff, 48, 40, 3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_HEX, 64'hdead_beef, -48, 40, 3'b101));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_HEX, 64'hffff_ffff_ffff_ffff, 63, 63,
                                        3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_PTR, 64'hffff_ffff_ffff_ffff, 20, 30,
                                        3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_PTR, 64'd0, -64, 0, 3'b111));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_PTR, 64'h1234, 24, -1, 3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'hffff_ff85, 10, -1, 3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_CHAR, 64'h41, 5, 9, 3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_CHAR, 64'hff, -64, -1, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_CHAR, 64'h00, 10, -1, 3'b001));
      pending_convs.push_back(make_conv(3'd6, 64'd5, 10, 3, 3'b000));
      pending_convs.push_back(make_conv(3'd7, 64'd5, 10, 3, 3'b000));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_SDEC, 64'h8000_0000, 48, 59, 3'b010));
      pending_convs.push_back(make_conv(itoa_pkg::MODE_OCT, 64'd8, 0, -64, 3'b100));
      for (k = 0; k < 310; k++) begin
         conv_type c;
         c.mode = 3'($urandom_range(0, 7));
         if (c.mode > itoa_pkg::MODE_CHAR && $urandom_range(0, 3) != 0)
            c.mode = 3'($urandom_range(0, 5));
         c.value = rand_value();
         c.fwidth = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12) - 6);
         c.prec = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 12) - 1);
         c.flags = 3'($urandom);
         pending_convs.push_back(c);
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      wait (pending_convs.size() < 40);
      no_idle = 1'b1;
      wait (pending_convs.size() == 0 && expected_chars.size() == 0);
      repeat (200) @(posedge clock);
      if (failed || expected_chars.size() != 0) begin
         $display("simulation failed");
      end else begin
         $display("simulation ok");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/itoa_pkg.sv
src/itoa_datapath.sv
src/itoa_ctrl.sv
src/integer_to_ascii_field_formatter_unit.sv
verif/testbench.sv
